// ----- sv/bdar_pkg.sv -----
// Shared types and constants for the button debounce and auto-repeat block.
`default_nettype none

package bdar_pkg;

    // Configuration port
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PER   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_EN    = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 24'd50000;
    localparam logic [CFG_W-1:0] REPEAT_DELAY_RST = 24'd400000;
    localparam logic [CFG_W-1:0] REPEAT_PER_RST   = 24'd200000;

    // Input item kinds and levels
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_EDGE     = 1'b1;
    localparam logic LVL_PRESSED = 1'b0;

    // Stream widths
    localparam int EV_W    = 2;
    localparam int TDATA_W = 8;

    // Output queue geometry
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PTR_W = 2;
    localparam int OFIFO_CNT_W = 3;

    // Results of one request: count (0..2) and up to two event codes
    typedef struct packed {
        logic [1:0]      cnt;
        logic [EV_W-1:0] ev0;
        logic [EV_W-1:0] ev1;
    } t_push;

endpackage

`default_nettype wire

// ----- sv/button_debounce_auto_repeat.sv -----
// Top level of the button debounce and auto-repeat block.
//
// Input stream: each request is one time tick (tuser low) or one button
// edge (tuser high) with the button number and its new level in tdata.
// Output stream: one event code per result in tdata; tlast marks the final
// result caused by a request. A tick whose repeat countdown expires gives
// one press code per held button, so zero, one or two results; an accepted
// edge gives one; a rejected edge gives none.
// Results of a request are written into the result queue at the edge that
// accepts it. A request is accepted in every cycle while the four-entry
// result queue has room for two more results; the queue gives out one
// result at a time, and so sets the sustained rate.
// Configuration is written through a plain write port (no read-back) and
// must only change while the block is idle.
// Reset clears the elapsed count, stops the repeat countdown, marks both
// buttons released and loads the register defaults. Edges arriving before
// the debounce window has elapsed after reset are dropped.
// When the receiver stalls, results wait in the queue and s_axis_tready
// falls once fewer than two entries are free.
`default_nettype none

module button_debounce_auto_repeat #(
    parameter int NUM_BUTTONS = 2
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Configuration write port
    input  wire                                 i_cfg_we,
    input  wire  [bdar_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [bdar_pkg::CFG_W-1:0]          i_cfg_data,
    // Input stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [bdar_pkg::TDATA_W-1:0]        s_axis_tdata,  // [0] button, [1] level
    input  wire                                 s_axis_tuser,  // [0] operation
    // Output stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [bdar_pkg::TDATA_W-1:0]        m_axis_tdata,  // [1:0] event_res
    output logic                                m_axis_tlast
);

    logic                        w_accept;
    logic                        w_room;
    logic [bdar_pkg::EV_W-1:0]   w_ev;
    bdar_pkg::t_push             w_push;

    assign s_axis_tready = w_room;
    assign w_accept      = s_axis_tvalid && w_room;

    // Request processing and state
    bdar_core #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_operation (s_axis_tuser),
        .i_button    (s_axis_tdata[0]),
        .i_level     (s_axis_tdata[1]),
        .o_push      (w_push)
    );

    // Result queue
    bdar_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_ev    (w_ev),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(bdar_pkg::TDATA_W - bdar_pkg::EV_W){1'b0}}, w_ev};

endmodule

`default_nettype wire

// ----- sv/bdar_core.sv -----
// Debounce filter, held-level tracking and repeat countdown, one request per cycle.
`default_nettype none

module bdar_core #(
    parameter int NUM_BUTTONS = 2
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [bdar_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [bdar_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire                              i_accept,
    input  wire                              i_operation,
    input  wire                              i_button,
    input  wire                              i_level,
    output bdar_pkg::t_push                  o_push
);

    localparam int HeldN = (NUM_BUTTONS < 2) ? NUM_BUTTONS : 2;
    localparam logic [bdar_pkg::CFG_W-1:0] SinceMax = '1;

    // Configuration registers
    logic [bdar_pkg::CFG_W-1:0] r_debounce;
    logic [bdar_pkg::CFG_W-1:0] r_delay;
    logic [bdar_pkg::CFG_W-1:0] r_period;
    logic                       r_rep_en;

    // Block state
    logic [bdar_pkg::CFG_W-1:0] r_since, n_since;
    logic [bdar_pkg::CFG_W-1:0] r_cd, n_cd;
    logic                       r_running, n_running;
    logic [HeldN-1:0]           r_held, n_held;

    logic       w_btn_ok;
    logic       w_edge_ok;
    logic [1:0] w_held2;
    logic       w_lp;
    logic       w_rp;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= bdar_pkg::DEBOUNCE_RST;
            r_delay    <= bdar_pkg::REPEAT_DELAY_RST;
            r_period   <= bdar_pkg::REPEAT_PER_RST;
            r_rep_en   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bdar_pkg::REG_DEBOUNCE:     r_debounce <= i_cfg_data;
                bdar_pkg::REG_REPEAT_DELAY: r_delay    <= i_cfg_data;
                bdar_pkg::REG_REPEAT_PER:   r_period   <= i_cfg_data;
                bdar_pkg::REG_REPEAT_EN:    r_rep_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // An edge counts only from a known button after the debounce window.
    assign w_btn_ok  = ({31'b0, i_button} < NUM_BUTTONS);
    assign w_edge_ok = i_accept && (i_operation == bdar_pkg::OP_EDGE) && w_btn_ok
                       && (r_since > r_debounce);

    // Held levels widened to two buttons; missing buttons read as released.
    always_comb begin
        w_held2 = 2'b11;
        for (int i = 0; i < HeldN; i++) begin
            w_held2[i] = r_held[i];
        end
    end
    assign w_lp = (w_held2[0] == bdar_pkg::LVL_PRESSED);
    assign w_rp = (w_held2[1] == bdar_pkg::LVL_PRESSED);

    // Next state and results of the current request
    always_comb begin
        n_since   = r_since;
        n_cd      = r_cd;
        n_running = r_running;
        n_held    = r_held;
        o_push    = '0;
        if (i_accept && (i_operation == bdar_pkg::OP_TICK)) begin
            if (r_since != SinceMax) begin
                n_since = r_since + 1'b1;
            end
            if (r_running) begin
                if (r_cd <= 24'd1) begin
                    // Expiry: one press code per held button, left first.
                    n_cd       = r_period;
                    o_push.cnt = {1'b0, w_lp} + {1'b0, w_rp};
                    o_push.ev0 = w_lp ? {1'b0, bdar_pkg::LVL_PRESSED}
                                      : {1'b1, bdar_pkg::LVL_PRESSED};
                    o_push.ev1 = {1'b1, bdar_pkg::LVL_PRESSED};
                end else begin
                    n_cd = r_cd - 1'b1;
                end
            end
        end else if (w_edge_ok) begin
            n_since    = '0;
            o_push.cnt = 2'd1;
            o_push.ev0 = {i_button, i_level};
            if (r_rep_en) begin
                if (i_level == bdar_pkg::LVL_PRESSED) begin
                    n_cd      = r_delay;
                    n_running = 1'b1;
                end else begin
                    n_running = 1'b0;
                end
            end
            for (int i = 0; i < HeldN; i++) begin
                if ({31'b0, i_button} == i) begin
                    n_held[i] = i_level;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since   <= '0;
            r_cd      <= '0;
            r_running <= 1'b0;
            r_held    <= '1;
        end else begin
            r_since   <= n_since;
            r_cd      <= n_cd;
            r_running <= n_running;
            r_held    <= n_held;
        end
    end

    // An accepted edge always restarts the elapsed-time count.
    a_since_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_edge_ok) |-> (r_since == '0))
        else $error("elapsed count not cleared after accepted edge");

    // The repeat countdown stops only on an accepted release with repeat on.
    a_stop_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_running)) |->
            $past(w_edge_ok && r_rep_en && (i_level != bdar_pkg::LVL_PRESSED)))
        else $error("repeat stopped without an accepted release");

    // A tick never gives more results than there are buttons held.
    a_tick_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd2) |-> (w_lp && w_rp && !w_edge_ok))
        else $error("two results without both buttons held");

endmodule

`default_nettype wire

// ----- sv/bdar_ofifo.sv -----
// Four-entry result queue taking up to two results a cycle and giving one.
`default_nettype none

module bdar_ofifo (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  bdar_pkg::t_push               i_push,
    output logic                                o_room,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [bdar_pkg::EV_W-1:0]           o_ev,
    output logic                                o_last
);

    localparam int EntW = bdar_pkg::EV_W + 1;

    logic [EntW-1:0]                  r_mem [bdar_pkg::OFIFO_DEPTH];
    logic [bdar_pkg::OFIFO_PTR_W-1:0] r_wr_ptr;
    logic [bdar_pkg::OFIFO_PTR_W-1:0] r_rd_ptr;
    logic [bdar_pkg::OFIFO_CNT_W-1:0] r_count;
    logic [bdar_pkg::OFIFO_PTR_W-1:0] w_wr_ptr1;
    logic                             w_pop;

    assign w_wr_ptr1 = r_wr_ptr + 1'b1;
    assign w_pop     = o_valid && i_ready;
    assign o_valid   = (r_count != '0);
    // Room for the worst case of two results from the next request
    assign o_room    = (r_count <= bdar_pkg::OFIFO_CNT_W'(bdar_pkg::OFIFO_DEPTH - 2));
    assign o_ev      = r_mem[r_rd_ptr][bdar_pkg::EV_W-1:0];
    assign o_last    = r_mem[r_rd_ptr][bdar_pkg::EV_W];

    // Entry storage; the final result of a request carries the last flag.
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= {(i_push.cnt == 2'd1), i_push.ev0};
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_wr_ptr1] <= {1'b1, i_push.ev1};
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push.cnt;
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + {1'b0, i_push.cnt} - {2'b0, w_pop};
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bdar_pkg::OFIFO_CNT_W'(bdar_pkg::OFIFO_DEPTH))
        else $error("result queue count beyond depth");

    // Results are pushed only when there is room for them.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_room)
        else $error("result queue push without room");

    // A single pop lowers the count by one when nothing is pushed.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && (i_push.cnt == 2'd0)) |=> (r_count == $past(r_count) - 1'b1))
        else $error("result queue count not lowered on pop");

endmodule

`default_nettype wire

// ----- tb/button_event_checker.sv -----
// Checker that predicts and compares the event codes of the button debounce block.
`timescale 1ns / 100ps

module button_event_checker
    import bdar_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Configuration writes as seen by the block
    input  wire                  i_cfg_we,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [CFG_W-1:0]     i_cfg_data,
    // Request channel
    input  wire                  i_req_valid,
    input  wire                  i_req_ready,
    input  wire  [TDATA_W-1:0]   i_req_data,   // [0] button, [1] level
    input  wire                  i_req_user,   // [0] operation
    // Result channel
    input  wire                  i_res_valid,
    input  wire                  i_res_ready,
    input  wire  [TDATA_W-1:0]   i_res_data,   // [1:0] event_res
    input  wire                  i_res_last,
    output int                   o_errors,
    output int                   o_awaited
);

    typedef struct packed {
        logic [EV_W-1:0] code;
        logic            last;
    } button_event_t;

    localparam logic [CFG_W-1:0] ELAPSED_MAX = '1;

    // Event codes still owed by the block, oldest first.
    button_event_t awaited_events[$];

    // Register copies.
    logic [CFG_W-1:0] debounce_lim;
    logic [CFG_W-1:0] delay_load;
    logic [CFG_W-1:0] period_load;
    logic             repeat_on;

    // Block state copies.
    logic [CFG_W-1:0] elapsed;
    logic [CFG_W-1:0] repeat_count;
    logic             repeat_running;
    logic [1:0]       held;

    int errors = 0;

    // Works out the event codes that one request causes and queues them.
    task automatic predict_button_events(input logic op, input logic btn, input logic lvl);
        button_event_t found [2];
        int n;
        n = 0;
        if (op == OP_TICK) begin
            if (elapsed != ELAPSED_MAX)
                elapsed = elapsed + 1'b1;
            if (repeat_running) begin
                if (repeat_count <= 24'd1) begin
                    // Repeat fires: one press code per held button, left first.
                    for (int b = 0; b < 2; b++) begin
                        if (held[b] == LVL_PRESSED) begin
                            found[n].code = {b[0], LVL_PRESSED};
                            found[n].last = 1'b0;
                            n++;
                        end
                    end
                    repeat_count = period_load;
                end else begin
                    repeat_count = repeat_count - 1'b1;
                end
            end
        end else if (elapsed > debounce_lim) begin
            // Edge outside the debounce window is taken.
            elapsed = '0;
            found[0].code = {btn, lvl};
            found[0].last = 1'b0;
            n = 1;
            if (repeat_on) begin
                if (lvl == LVL_PRESSED) begin
                    repeat_count   = delay_load;
                    repeat_running = 1'b1;
                end else begin
                    repeat_running = 1'b0;
                end
            end
            held[btn] = lvl;
        end
        if (n > 0)
            found[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            awaited_events.push_back(found[k]);
    endtask

    // Follow both channels and the register port at every edge.
    always @(posedge i_clk) begin : watch
        button_event_t seen;
        if (!i_rst_n) begin
            debounce_lim   = DEBOUNCE_RST;
            delay_load     = REPEAT_DELAY_RST;
            period_load    = REPEAT_PER_RST;
            repeat_on      = 1'b1;
            elapsed        = '0;
            repeat_count   = '0;
            repeat_running = 1'b0;
            held           = 2'b11;
            awaited_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DEBOUNCE:     debounce_lim = i_cfg_data;
                    REG_REPEAT_DELAY: delay_load   = i_cfg_data;
                    REG_REPEAT_PER:   period_load  = i_cfg_data;
                    REG_REPEAT_EN:    repeat_on    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                predict_button_events(i_req_user, i_req_data[0], i_req_data[1]);
            if (i_res_valid && i_res_ready) begin
                if (awaited_events.size() == 0) begin
                    $error("unexpected result: event_res %0d, last %0d",
                           i_res_data[EV_W-1:0], i_res_last);
                    errors++;
                end else begin
                    seen = awaited_events.pop_front();
                    if (i_res_data[EV_W-1:0] !== seen.code) begin
                        $error("event_res mismatch: expected %0d, actual %0d",
                               seen.code, i_res_data[EV_W-1:0]);
                        errors++;
                    end
                    if (i_res_last !== seen.last) begin
                        $error("last mismatch: expected %0d, actual %0d",
                               seen.last, i_res_last);
                        errors++;
                    end
                end
            end
        end
        o_errors  <= errors;
        o_awaited <= awaited_events.size();
    end

endmodule

// ----- tb/button_debounce_auto_repeat_tb.sv -----
// Top of the testbench: clock, reset, requests, register phases and the verdict.
`timescale 1ns / 100ps

module button_debounce_auto_repeat_tb;
    import bdar_pkg::*;

    localparam logic BTN_LEFT     = 1'b0;
    localparam logic BTN_RIGHT    = 1'b1;
    localparam logic LVL_RELEASED = ~LVL_PRESSED;
    localparam logic [CFG_W-1:0] CFG_MAX = '1;

    typedef enum int {
        DRAIN_FULL,
        DRAIN_HALF,
        DRAIN_SPARSE,
        DRAIN_MOSTLY
    } drain_mode_e;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_data    = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;  // [0] button, [1] level
    logic               s_axis_tuser  = 1'b0; // [0] operation
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // [1:0] event_res
    logic               m_axis_tlast;

    int errors;
    int awaited;

    drain_mode_e drain_mode = DRAIN_FULL;
    int drain_left = 0;
    int burst_left = 1;
    logic [1:0] next_lvl = 2'b00;

    button_debounce_auto_repeat DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    button_event_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_res_last  (m_axis_tlast),
        .o_errors    (errors),
        .o_awaited   (awaited)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver switches between randomly chosen drain patterns.
    always @(posedge i_clk) begin
        if (drain_left == 0) begin
            drain_mode = drain_mode_e'($urandom_range(0, 3));
            drain_left = $urandom_range(16, 96);
        end else begin
            drain_left--;
        end
        case (drain_mode)
            DRAIN_FULL:   m_axis_tready <= 1'b1;
            DRAIN_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
            DRAIN_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:      m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Hold the sender until the block owes nothing.
    task automatic wait_drained();
        do @(posedge i_clk); while (awaited != 0);
    endtask

    // Offer one request and wait for the edge that takes it; bursts and gaps
    // between bursts are decided here.
    task automatic issue(input logic op, input logic btn, input logic lvl);
        logic [TDATA_W-1:0] word;
        word    = '0;
        word[0] = btn;
        word[1] = lvl;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            else
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Let the block go idle, then load a full register set.
    task automatic configure(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] dly,
                             input logic [CFG_W-1:0] per, input logic en);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_REPEAT_DELAY, dly);
        write_reg(REG_REPEAT_PER, per);
        write_reg(REG_REPEAT_EN, {{(CFG_W-1){1'b0}}, en});
        i_cfg_we <= 1'b0;
    endtask

    // Mostly ticks and alternating press/release edges, with some odd edges mixed in.
    task automatic run_random(input int count);
        logic btn;
        logic lvl;
        repeat (count) begin
            if ($urandom_range(0, 99) < 55) begin
                issue(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                btn = 1'($urandom_range(0, 1));
                lvl = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1))
                                                  : next_lvl[btn];
                issue(OP_EDGE, btn, lvl);
                next_lvl[btn] = ~lvl;
            end
        end
    endtask

    initial begin : stimulus
        int waited;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: edges this soon after reset fall in the debounce window.
        issue(OP_EDGE, BTN_LEFT, LVL_PRESSED);
        issue(OP_TICK, BTN_LEFT, LVL_PRESSED);
        issue(OP_TICK, BTN_RIGHT, LVL_RELEASED);
        issue(OP_EDGE, BTN_RIGHT, LVL_RELEASED);

        // No debounce and the shortest repeat: single and double repeats,
        // an edge rejected right after an accepted one, repeat stopped by release.
        configure('0, 24'd1, 24'd1, 1'b1);
        issue(OP_EDGE, BTN_LEFT, LVL_PRESSED);
        issue(OP_TICK, BTN_LEFT, LVL_PRESSED);
        issue(OP_EDGE, BTN_RIGHT, LVL_PRESSED);
        issue(OP_EDGE, BTN_RIGHT, LVL_RELEASED);
        issue(OP_TICK, BTN_RIGHT, LVL_RELEASED);
        issue(OP_TICK, BTN_LEFT, LVL_RELEASED);
        issue(OP_EDGE, BTN_RIGHT, LVL_RELEASED);
        issue(OP_TICK, BTN_LEFT, LVL_PRESSED);
        issue(OP_TICK, BTN_RIGHT, LVL_PRESSED);
        issue(OP_EDGE, BTN_LEFT, LVL_RELEASED);
        issue(OP_TICK, BTN_LEFT, LVL_PRESSED);
        issue(OP_EDGE, BTN_RIGHT, LVL_PRESSED);
        issue(OP_TICK, BTN_RIGHT, LVL_PRESSED);
        issue(OP_EDGE, BTN_RIGHT, LVL_RELEASED);
        issue(OP_TICK, BTN_LEFT, LVL_RELEASED);

        // Random phases over a spread of register settings.
        configure(24'd3, 24'd7, 24'd3, 1'b1);
        run_random(400);
        // Zero delay and period expire on the next tick.
        configure('0, '0, '0, 1'b1);
        run_random(200);
        // Repeat disabled: a running countdown keeps going.
        configure(24'd2, 24'd5, 24'd2, 1'b0);
        run_random(250);
        // Everything at all ones: no edge can ever be taken.
        configure(CFG_MAX, CFG_MAX, CFG_MAX, 1'b1);
        run_random(150);
        configure(24'd1, 24'd4, CFG_MAX, 1'b1);
        run_random(250);
        configure('0, 24'd2, 24'd1, 1'b1);
        run_random(400);
        configure(24'd10, 24'd30, 24'd8, 1'b1);
        run_random(300);

        // Drain whatever is still owed, then give the verdict.
        s_axis_tvalid <= 1'b0;
        for (waited = 0; awaited != 0 && waited < 2000; waited++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (awaited != 0)
            $error("%0d expected results never arrived", awaited);
        if (errors == 0 && awaited == 0) begin
            $display("button_debounce_auto_repeat_tb: PASS");
        end else begin
            $display("button_debounce_auto_repeat_tb: FAIL");
        end
        $finish;
    end

    // Hard stop in case the handshakes hang.
    initial begin
        #5_000_000;
        $display("button_debounce_auto_repeat_tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/bdar_pkg.sv
sv/bdar_core.sv
sv/bdar_ofifo.sv
sv/button_debounce_auto_repeat.sv
tb/button_event_checker.sv
tb/button_debounce_auto_repeat_tb.sv
